// ===== src/sorted_array_table_assert.svh =====
// Assertion macros for the sorted array table RTL.
// Included by sat_dp, the only module that checks its own logic; no other dependencies.
`ifndef SORTED_ARRAY_TABLE_ASSERT_SVH
`define SORTED_ARRAY_TABLE_ASSERT_SVH
`ifndef SYNTH
`define SAT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SAT_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/sat_pkg.sv =====
// Shared constants and types for the sorted array table.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package sat_pkg;

  localparam int Depth = 64;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int DataW = 32;
  localparam int CfgAddrW = 3;

  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActLookup = 2'd1;
  localparam logic [1:0] ActRemove = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StIndex = 2'd2;

  localparam logic CfgCapacity = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS,
    S_REM,
    S_LOOK
  } sat_state_t;

  typedef enum logic [2:0] {
    RD_TOP,
    RD_POS,
    RD_POSNEXT,
    RD_DOWN,
    RD_UP
  } sat_rd_sel_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_CNT,
    PTR_POS,
    PTR_DEC,
    PTR_INC
  } sat_ptr_sel_t;

  typedef struct packed {
    logic         load;
    sat_rd_sel_t  rd_sel;
    sat_ptr_sel_t ptr_sel;
    logic         wr;
    logic         wr_val;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         resp;
    logic [1:0]   resp_status;
    logic         resp_read;
  } sat_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       full;
    logic       bad_index;
    logic       last_pos;
    logic       last_ptr;
    logic       ptr_zero;
    logic       ge;
  } sat_stat_t;

endpackage
`default_nettype wire

// ===== src/sorted_array_table.sv =====
// Top level of the sorted array table: configuration port, controller and datapath.
// Depends on sat_pkg, sat_ctrl and sat_dp.
//
// Each accepted word (start high while busy is low) yields exactly one result word,
// shown for a single cycle with done high; the receiver cannot stall it. A refused insert,
// a bad index, an unused action or the removal of the last entry are answered from the
// decode step, and a lookup from the read step after it. An insert then shifts every
// stored entry not less than the new value up by one place before it writes the value,
// and a remove shifts every entry above the removed index down by one place, so the
// longest word is an insert in front of 63 stored entries. The pace is set by the entry
// memory, which has one read and one write port and moves one entry per cycle. busy
// stays high until the result is driven, and the next word may be offered in the cycle
// that done is high.
`default_nettype none
module sorted_array_table import sat_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          action,
  input  wire logic [DataW-1:0]    item_value,
  input  wire logic [AddrW-1:0]    position,
  output logic                     done,
  output logic [DataW-1:0]         read_value,
  output logic [1:0]               status,
  output logic [CntW-1:0]          entry_total
);

  logic [CntW-1:0] capacity;
  sat_cmd_t        cmd;
  sat_stat_t       stat;

  assign pready = 1'b1;
  assign prdata = (paddr[CfgAddrW-1] == CfgCapacity) ? {{(32 - CntW){1'b0}}, capacity} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CntW'(Depth);
    end else if (psel && penable && pwrite && (paddr[CfgAddrW-1] == CfgCapacity)) begin
      capacity <= pwdata[CntW-1:0];
    end
  end

  sat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sat_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .action      (action),
    .item_value  (item_value),
    .position    (position),
    .capacity    (capacity),
    .stat        (stat),
    .done        (done),
    .read_value  (read_value),
    .status      (status),
    .entry_total (entry_total)
  );

endmodule
`default_nettype wire

// ===== src/sat_dp.sv =====
// Datapath of the sorted array table: entry memory, count, pointer and result words.
// Depends on sat_pkg and the assertion macros in sorted_array_table_assert.svh.
`default_nettype none
`include "sorted_array_table_assert.svh"
module sat_dp import sat_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sat_cmd_t         cmd,
  input  wire logic [1:0]       action,
  input  wire logic [DataW-1:0] item_value,
  input  wire logic [AddrW-1:0] position,
  input  wire logic [CntW-1:0]  capacity,
  output sat_stat_t             stat,
  output logic                  done,
  output logic [DataW-1:0]      read_value,
  output logic [1:0]            status,
  output logic [CntW-1:0]       entry_total
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_data;
  logic [AddrW-1:0] rd_addr;
  logic [DataW-1:0] wr_data;
  logic [1:0]       act;
  logic [DataW-1:0] val;
  logic [AddrW-1:0] pos;
  logic [AddrW-1:0] ptr;
  logic [AddrW-1:0] ptr_next;
  logic [CntW-1:0]  cnt;
  logic [CntW-1:0]  cnt_next;
  logic [CntW-1:0]  limit;

  always_comb begin
    case (cmd.rd_sel)
      RD_TOP:     rd_addr = cnt[AddrW-1:0] - AddrW'(1);
      RD_POS:     rd_addr = pos;
      RD_POSNEXT: rd_addr = pos + AddrW'(1);
      RD_DOWN:    rd_addr = ptr - AddrW'(2);
      RD_UP:      rd_addr = ptr + AddrW'(2);
      default:    rd_addr = pos;
    endcase
  end

  always_comb begin
    case (cmd.ptr_sel)
      PTR_HOLD: ptr_next = ptr;
      PTR_CNT:  ptr_next = cnt[AddrW-1:0];
      PTR_POS:  ptr_next = pos;
      PTR_DEC:  ptr_next = ptr - AddrW'(1);
      PTR_INC:  ptr_next = ptr + AddrW'(1);
      default:  ptr_next = ptr;
    endcase
  end

  always_comb begin
    cnt_next = cnt;
    if (cmd.cnt_inc) begin
      cnt_next = cnt + CntW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_next = cnt - CntW'(1);
    end
  end

  assign wr_data = cmd.wr_val ? val : rd_data;
  assign limit   = (capacity > CntW'(Depth)) ? CntW'(Depth) : capacity;

  assign stat.act       = act;
  assign stat.full      = (cnt >= limit);
  assign stat.bad_index = ({1'b0, pos} >= cnt);
  assign stat.last_pos  = (({1'b0, pos} + CntW'(1)) == cnt);
  assign stat.last_ptr  = (({1'b0, ptr} + CntW'(2)) == cnt);
  assign stat.ptr_zero  = (ptr == '0);
  assign stat.ge        = (rd_data >= val);

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[ptr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      val <= item_value;
      pos <= position;
    end
    ptr         <= ptr_next;
    read_value  <= cmd.resp_read ? rd_data : '0;
    status      <= cmd.resp_status;
    entry_total <= cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      done <= cmd.resp;
    end
  end

  `SAT_ASSERT_IMPL(a_cnt_bound, clk, rst, 1'b1, cnt <= CntW'(Depth), "count exceeds depth")
  `SAT_ASSERT_IMPL(a_inc_not_full, clk, rst, cmd.cnt_inc, !stat.full && !cmd.cnt_dec,
                   "insert committed into a full table")
  `SAT_ASSERT_IMPL(a_err_zero, clk, rst, done && (status != StOk), read_value == '0,
                   "error result carries a nonzero word")

endmodule
`default_nettype wire

// ===== src/sat_ctrl.sv =====
// Controller of the sorted array table: sequences decode, shift and lookup steps.
// Depends on sat_pkg; drives the datapath through sat_cmd_t and reads sat_stat_t.
`default_nettype none
module sat_ctrl import sat_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire sat_stat_t stat,
  output sat_cmd_t       cmd,
  output logic           busy
);

  sat_state_t state;
  sat_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = RD_POS;
    cmd.ptr_sel = PTR_HOLD;
    state_next  = state;
    busy        = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.act)
          ActInsert: begin
            if (stat.full) begin
              cmd.resp        = 1'b1;
              cmd.resp_status = StFull;
              state_next      = S_IDLE;
            end else begin
              cmd.ptr_sel = PTR_CNT;
              cmd.rd_sel  = RD_TOP;
              state_next  = S_INS;
            end
          end
          ActLookup: begin
            if (stat.bad_index) begin
              cmd.resp        = 1'b1;
              cmd.resp_status = StIndex;
              state_next      = S_IDLE;
            end else begin
              cmd.rd_sel = RD_POS;
              state_next = S_LOOK;
            end
          end
          ActRemove: begin
            if (stat.bad_index) begin
              cmd.resp        = 1'b1;
              cmd.resp_status = StIndex;
              state_next      = S_IDLE;
            end else if (stat.last_pos) begin
              cmd.cnt_dec = 1'b1;
              cmd.resp    = 1'b1;
              state_next  = S_IDLE;
            end else begin
              cmd.ptr_sel = PTR_POS;
              cmd.rd_sel  = RD_POSNEXT;
              state_next  = S_REM;
            end
          end
          default: begin
            cmd.resp   = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_INS: begin
        cmd.wr = 1'b1;
        if (stat.ptr_zero || !stat.ge) begin
          cmd.wr_val  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.resp    = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.ptr_sel = PTR_DEC;
          cmd.rd_sel  = RD_DOWN;
        end
      end
      S_REM: begin
        cmd.wr = 1'b1;
        if (stat.last_ptr) begin
          cmd.cnt_dec = 1'b1;
          cmd.resp    = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.ptr_sel = PTR_INC;
          cmd.rd_sel  = RD_UP;
        end
      end
      S_LOOK: begin
        cmd.resp      = 1'b1;
        cmd.resp_read = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
